// ===== src/nrfs_pkg.sv =====
// ----------------------------------------------------------------------------
// nrfs_pkg
// Types and constants shared by the neighbor repulsion force summer.
// ----------------------------------------------------------------------------
package nrfs_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned GAIN_W  = 32;
    localparam int unsigned SUM_W   = 22;
    localparam int unsigned UNIT_W  = 18;
    localparam int unsigned FORCE_W = 48;
    localparam int unsigned MAX_NEIGHBORS_DEF = 16;

    // Request types carried by an input word.
    localparam logic [1:0] REQ_DROPLET = 2'd0;
    localparam logic [1:0] REQ_BODY    = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DROPLET_GAIN = 2'd0;
    localparam logic [1:0] CFG_BODY_GAIN    = 2'd1;
    localparam logic [1:0] CFG_ENABLED      = 2'd2;

    // Reset gain is 300.0 in Q16.16.
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd19660800;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [POS_W-1:0] self_x;
        logic signed [POS_W-1:0] self_y;
        logic signed [POS_W-1:0] self_z;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
        logic signed [POS_W-1:0] other_z;
        logic                    last_item;
    } t_in_word;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      clipped;
    } t_out_word;

endpackage

// ===== src/neighbor_repulsion_force_sum_core.sv =====
// ----------------------------------------------------------------------------
// neighbor_repulsion_force_sum_core
// Sums unit repulsion directions of droplet and body neighbors over one tick
// and, when enabled, emits the gained total force on the tick's last word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | t_in_word
//  out     | output    | o_out_valid / i_out_stall | t_out_word
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// After its accept edge a word stalls the input until it is done: a taken
// neighbor normalizes (shifts until its largest magnitude leads in bit 30,
// then a final check), squares, takes 32 square-root steps and three divides
// of 17 quotient bits, then accumulates, with every product on one shared
// multiplier. A zero difference goes from its first normalize cycle to accumulate,
// a word that adds nothing only accumulates, and a tick close adds a force pass.
// Reset is synchronous; it clears the sums, counts and handshake state.
// An output word waits in its register under stall; a new input word is taken
// meanwhile, and only the next force pass waits for the register to empty.
module neighbor_repulsion_force_sum_core #(
    parameter int unsigned MAX_NEIGHBORS = nrfs_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  nrfs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nrfs_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import nrfs_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_NORM  = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_ACC   = 7'b0100000,
        S_FORCE = 7'b1000000
    } t_state;

    t_state r_state;
    logic [5:0] r_cnt;
    logic [1:0] r_ci;

    logic [GAIN_W-1:0] r_dgain, r_bgain;
    logic              r_enabled;

    logic signed [SUM_W-1:0] r_dsum [3];
    logic signed [SUM_W-1:0] r_bsum [3];
    logic [CNT_W-1:0] r_dcnt, r_bcnt;

    logic        r_take, r_is_body, r_last;
    logic        r_sign [3];
    logic [32:0] r_mag [3];
    logic signed [UNIT_W-1:0] r_unit [3];

    logic signed [65:0] r_prod;
    logic [63:0] r_sq;
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [16:0] r_num;
    logic [16:0] r_quo;
    logic signed [54:0] r_facc;

    logic      r_out_valid;
    t_out_word r_out;

    // Configuration port is always open.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dgain   <= GAIN_RESET;
            r_bgain   <= GAIN_RESET;
            r_enabled <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DROPLET_GAIN: r_dgain   <= i_cfg_data;
                CFG_BODY_GAIN:    r_bgain   <= i_cfg_data;
                CFG_ENABLED:      r_enabled <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Input differences, formed exactly in 33 bits.
    logic signed [32:0] w_diff [3];
    always_comb begin
        w_diff[0] = 33'(i_in_word.self_x) - 33'(i_in_word.other_x);
        w_diff[1] = 33'(i_in_word.self_y) - 33'(i_in_word.other_y);
        w_diff[2] = 33'(i_in_word.self_z) - 33'(i_in_word.other_z);
    end

    // Largest magnitude for the normalize step.
    logic [32:0] w_mx;
    always_comb begin
        w_mx = r_mag[0];
        if (r_mag[1] > w_mx) begin
            w_mx = r_mag[1];
        end
        if (r_mag[2] > w_mx) begin
            w_mx = r_mag[2];
        end
    end

    // Shared multiplier operand selection.
    logic signed [32:0] w_ma, w_mb;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_SQ) begin
            w_ma = {2'b00, r_mag[r_cnt[1:0]][30:0]};
            w_mb = {2'b00, r_mag[r_cnt[1:0]][30:0]};
        end else begin
            w_ma = r_cnt[0] ? 33'(signed'(r_bgain)) : 33'(signed'(r_dgain));
            w_mb = r_cnt[0] ? 33'(r_bsum[r_cnt[2:1]]) : 33'(r_dsum[r_cnt[2:1]]);
        end
    end

    // Square-root step.
    logic [34:0] w_rem2;
    logic [34:0] w_trial;
    logic        w_rbit;
    always_comb begin
        w_rem2  = {r_rem[32:0], r_rad[63:62]};
        w_trial = {1'b0, r_root, 2'b01};
        w_rbit  = (w_rem2 >= w_trial);
    end

    // Divide step and numerator of the rounded quotient.
    logic [32:0] w_drem2;
    logic        w_qbit;
    logic [16:0] w_qnext;
    logic [47:0] w_numer;
    logic signed [UNIT_W-1:0] w_unit;
    always_comb begin
        w_drem2 = {r_rem[31:0], r_num[16]};
        w_qbit  = (w_drem2 >= {1'b0, r_root});
        w_qnext = {r_quo[15:0], w_qbit};
        w_numer = {1'b0, r_mag[r_ci][30:0], 16'b0} + {17'b0, r_root[31:1]};
        w_unit  = r_sign[r_ci] ? -UNIT_W'({1'b0, w_qnext}) : UNIT_W'({1'b0, w_qnext});
    end

    // Force total rounded to Q32.16; its range never reaches 48 bits.
    logic signed [54:0] w_ftot;
    logic signed [38:0] w_fround;
    always_comb begin
        w_ftot   = r_facc + r_prod[54:0];
        w_fround = 39'((w_ftot + 55'sd32768) >>> 16);
    end

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [UNIT_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = 23'(a) + 23'(b);
        if (s[SUM_W] != s[SUM_W-1]) begin
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ci        <= '0;
            r_dcnt      <= '0;
            r_bcnt      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_dsum[i] <= '0;
                r_bsum[i] <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_prod <= w_ma * w_mb;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last    <= i_in_word.last_item;
                        r_is_body <= (i_in_word.req_type == REQ_BODY);
                        for (int i = 0; i < 3; i++) begin
                            r_sign[i] <= w_diff[i][32];
                            r_mag[i]  <= w_diff[i][32] ? -w_diff[i] : w_diff[i];
                        end
                        if ((i_in_word.req_type == REQ_DROPLET &&
                             r_dcnt < CNT_W'(MAX_NEIGHBORS)) ||
                            (i_in_word.req_type == REQ_BODY &&
                             r_bcnt < CNT_W'(MAX_NEIGHBORS))) begin
                            r_take  <= 1'b1;
                            r_state <= S_NORM;
                        end else begin
                            r_take  <= 1'b0;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_NORM: begin
                    r_cnt <= '0;
                    if (w_mx == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_unit[i] <= '0;
                        end
                        r_state <= S_ACC;
                    end else if (w_mx[32] || w_mx[31]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                    end else if (!w_mx[30]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt == 6'd3) begin
                        r_rad   <= r_sq + r_prod[63:0];
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd1) begin
                            r_sq <= r_prod[63:0];
                        end else if (r_cnt == 6'd2) begin
                            r_sq <= r_sq + r_prod[63:0];
                        end
                    end
                end
                S_SQRT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= w_rbit ? (w_rem2 - w_trial) : w_rem2;
                    r_root <= {r_root[30:0], w_rbit};
                    if (r_cnt == 6'd31) begin
                        r_cnt   <= '0;
                        r_ci    <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_cnt <= r_cnt + 6'd1;
                        r_rem <= {4'b0, w_numer[47:17]};
                        r_num <= w_numer[16:0];
                        r_quo <= '0;
                    end else begin
                        r_rem <= {2'b0, w_qbit ? (w_drem2 - {1'b0, r_root}) : w_drem2};
                        r_num <= r_num << 1;
                        r_quo <= w_qnext;
                        if (r_cnt == 6'd17) begin
                            r_unit[r_ci] <= w_unit;
                            r_cnt        <= '0;
                            r_ci         <= r_ci + 2'd1;
                            if (r_ci == 2'd2) begin
                                r_state <= S_ACC;
                            end
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                end
                S_ACC: begin
                    // A disabled tick close clears; otherwise a taken word adds.
                    if (r_last && !r_enabled) begin
                        for (int i = 0; i < 3; i++) begin
                            r_dsum[i] <= '0;
                            r_bsum[i] <= '0;
                        end
                        r_dcnt <= '0;
                        r_bcnt <= '0;
                    end else if (r_take) begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_is_body) begin
                                r_bsum[i] <= sat_add(r_bsum[i], r_unit[i]);
                            end else begin
                                r_dsum[i] <= sat_add(r_dsum[i], r_unit[i]);
                            end
                        end
                        if (r_is_body) begin
                            r_bcnt <= r_bcnt + CNT_W'(1);
                        end else begin
                            r_dcnt <= r_dcnt + CNT_W'(1);
                        end
                    end
                    r_cnt <= '0;
                    if (r_last && r_enabled) begin
                        r_state <= S_FORCE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FORCE: begin
                    // The first product waits until the output register is free.
                    if (r_cnt == 6'd6) begin
                        r_cnt <= '0;
                    end else if (r_cnt != 6'd0 || !r_out_valid) begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                    if (r_cnt == 6'd1 || r_cnt == 6'd3 || r_cnt == 6'd5) begin
                        r_facc <= r_prod[54:0];
                    end
                    if (r_cnt == 6'd2) begin
                        r_out.force_x <= FORCE_W'(w_fround);
                    end
                    if (r_cnt == 6'd4) begin
                        r_out.force_y <= FORCE_W'(w_fround);
                    end
                    if (r_cnt == 6'd6) begin
                        r_out.force_z <= FORCE_W'(w_fround);
                        r_out.clipped <= 1'b0;
                        r_out_valid   <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_dsum[i] <= '0;
                            r_bsum[i] <= '0;
                        end
                        r_dcnt  <= '0;
                        r_bcnt  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/nrfs_checker.sv =====
// ----------------------------------------------------------------------------
// nrfs_checker
// Port-level checks for the neighbor repulsion force summer.
// ----------------------------------------------------------------------------
module nrfs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input nrfs_pkg::t_out_word o_out_word
);
    // A stalled output word holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // A new result only appears after the block has been working on a word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

    // An accepted word keeps the block busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block free right after accepting a word");

    // Nothing is shown in the cycle after reset.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind neighbor_repulsion_force_sum_core nrfs_checker u_nrfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
